>>> hw/rtl/skrt_pkg.sv
// Shared types and codes for the sorted key record table.
// Holds the record layout, the command and status codes and default sizes.
// No dependencies.
package skrt_pkg;

	localparam int DEPTH_DEFAULT = 64;

	localparam int KEY_W   = 64;
	localparam int OWNER_W = 64;
	localparam int COUNT_W = 32;
	localparam int ROLE_W  = 32;
	localparam int TREF_W  = 64;
	localparam int DELTA_W = 32;
	localparam int SLOT_W  = 6;
	localparam int STAT_W  = 3;
	localparam int CMD_W   = 2;
	localparam int LIMIT_W = 7;
	localparam int CFG_W   = 32;

	// operation codes
	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADJUST  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FIND    = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_ZERO_KEY  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_DUP       = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd5;

	// configuration register indexes
	localparam logic REG_TABLE_LIMIT   = 1'b0;
	localparam logic REG_RELEASED_ROLE = 1'b1;

	// one stored record
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [OWNER_W-1:0] owner;
		logic [COUNT_W-1:0] count;
		logic [ROLE_W-1:0]  role;
		logic [TREF_W-1:0]  tref;
	} rec_t;

endpackage

>>> hw/rtl/sorted_key_record_table.sv
// Sorted key record table: storage, search sequencer and result register.
// Depends on skrt_pkg for the record layout and the command and status codes.
//
// Usage:
//   Commands arrive as beats on the s_ channel (tuser = command, tdata = key and
//   insert values and delta). Each command yields one result beat on the m_
//   channel (tuser = status, tdata = slot and the record fields).
//   Records live in one single-port-write, registered-read memory of DEPTH words,
//   kept in ascending key order. One 64-bit comparator scans the occupied entries
//   one per cycle until it meets the key or a larger one; an insert then moves the
//   later records up one per cycle through the same memory port.
//   An insert with a zero key, or one on a full table, is answered without a scan.
//   Other commands scan until they meet the key or a larger one or run past the
//   occupied entries; an insert at the end moves no records. The scan plus the
//   shift set the worst case. One command is in work at a time; s_tready rises
//   once the result enters the output register. A result stalled on m_tready
//   holds the next one in a holding register and keeps s_tready low. Reset empties
//   the table (no clearing pass), sets table_limit to 64 and released_role to 0;
//   write configuration only while the block is idle.
module sorted_key_record_table #(
	parameter int DEPTH = skrt_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic                       cfg_addr,
	input  logic [skrt_pkg::CFG_W-1:0] cfg_wdata,
	// command beats
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// from bit 0: key, owner_id, start_count, role_value, tracking_ref, delta
	input  logic [287:0]               s_tdata,
	// cmd
	input  logic [skrt_pkg::CMD_W-1:0] s_tuser,
	// result beats
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// from bit 0: slot, count_out, owner_out, role_out, ref_out, two zero bits
	output logic [199:0]               m_tdata,
	// status
	output logic [skrt_pkg::STAT_W-1:0] m_tuser
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SEARCH = 6'b000010,
		S_CHECK  = 6'b000100,
		S_SHIFT  = 6'b001000,
		S_PLACE  = 6'b010000,
		S_UPDATE = 6'b100000
	} state_t;

	state_t state_q;

	// configuration and table control
	logic [skrt_pkg::LIMIT_W-1:0] table_limit_q;
	logic [skrt_pkg::ROLE_W-1:0]  released_role_q;
	logic [CW-1:0]                occ_q;

	// latched command
	logic [skrt_pkg::CMD_W-1:0]   cmd_q;
	logic [skrt_pkg::KEY_W-1:0]   key_q;
	logic [skrt_pkg::OWNER_W-1:0] owner_q;
	logic [skrt_pkg::COUNT_W-1:0] start_q;
	logic [skrt_pkg::ROLE_W-1:0]  role_q;
	logic [skrt_pkg::TREF_W-1:0]  tref_q;
	logic [skrt_pkg::DELTA_W-1:0] delta_q;

	// search and shift sequencing
	logic [CW-1:0] scan_q;
	logic          rd_pend_q;
	logic [AW-1:0] rd_at_q;
	logic          hit_q;
	logic [CW-1:0] hit_idx_q;
	logic [AW-1:0] sh_q;
	logic          wb_pend_q;
	logic [AW-1:0] wb_at_q;
	skrt_pkg::rec_t rec_q;

	// record memory
	skrt_pkg::rec_t mem_q [DEPTH];
	skrt_pkg::rec_t rd_q;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	skrt_pkg::rec_t wr_data;
	logic [AW-1:0]  rd_addr;

	// pending result and output register
	logic                        res_pend_q;
	logic [skrt_pkg::STAT_W-1:0] res_status_q;
	logic [skrt_pkg::SLOT_W-1:0] res_slot_q;
	skrt_pkg::rec_t              res_rec_q;
	logic                        m_tvalid_q;
	logic [skrt_pkg::STAT_W-1:0] out_status_q;
	logic [skrt_pkg::SLOT_W-1:0] out_slot_q;
	skrt_pkg::rec_t              out_rec_q;

	logic                        accept;
	logic                        out_load;
	logic                        cmp_eq;
	logic                        cmp_gt;
	logic                        search_stop;
	logic                        full;
	logic                        res_ld;
	logic [skrt_pkg::STAT_W-1:0] res_status_n;
	logic [skrt_pkg::SLOT_W-1:0] res_slot_n;
	skrt_pkg::rec_t              res_rec_n;
	skrt_pkg::rec_t              new_rec;
	skrt_pkg::rec_t              upd_rec;
	logic [skrt_pkg::COUNT_W-1:0] remove;
	logic                        underflow;
	logic [31:0]                 hit_idx32;

	assign s_tready = (state_q == S_IDLE) && !res_pend_q;
	assign accept   = s_tvalid && s_tready;
	assign out_load = res_pend_q && (!m_tvalid_q || m_tready);

	// shared key comparator
	assign cmp_eq      = (rd_q.key == key_q);
	assign cmp_gt      = (rd_q.key > key_q);
	assign search_stop = rd_pend_q && (cmp_eq || cmp_gt);

	// effective limit is the smaller of the register and the depth
	assign full = (32'(occ_q) >= 32'(table_limit_q)) || (32'(occ_q) >= DEPTH);

	assign hit_idx32 = 32'(hit_idx_q);

	// record built by insert; zero reference defaults to the key
	always_comb begin
		new_rec.key   = key_q;
		new_rec.owner = owner_q;
		new_rec.count = start_q;
		new_rec.role  = role_q;
		new_rec.tref  = (tref_q != '0) ? tref_q : key_q;
	end

	// adjust, release or find applied to the found record
	always_comb begin
		remove    = skrt_pkg::COUNT_W'(0) - delta_q;
		underflow = (cmd_q == skrt_pkg::CMD_ADJUST) && delta_q[skrt_pkg::DELTA_W-1]
			&& (remove > rec_q.count);
		upd_rec   = rec_q;
		case (cmd_q)
			skrt_pkg::CMD_ADJUST: begin
				upd_rec.count = rec_q.count + delta_q;
			end
			skrt_pkg::CMD_RELEASE: begin
				upd_rec.owner = '0;
				upd_rec.count = '0;
				upd_rec.role  = released_role_q;
			end
			default: begin
				upd_rec = rec_q;
			end
		endcase
	end

	// memory port steering and result selection
	always_comb begin
		rd_addr      = scan_q[AW-1:0];
		wr_en        = 1'b0;
		wr_addr      = wb_at_q;
		wr_data      = rd_q;
		res_ld       = 1'b0;
		res_status_n = skrt_pkg::ST_OK;
		res_slot_n   = '0;
		res_rec_n    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && (s_tuser == skrt_pkg::CMD_INSERT)) begin
					if (s_tdata[63:0] == '0) begin
						res_ld       = 1'b1;
						res_status_n = skrt_pkg::ST_ZERO_KEY;
					end else if (full) begin
						res_ld       = 1'b1;
						res_status_n = skrt_pkg::ST_FULL;
					end
				end
			end
			S_CHECK: begin
				if (cmd_q == skrt_pkg::CMD_INSERT) begin
					if (hit_q) begin
						res_ld       = 1'b1;
						res_status_n = skrt_pkg::ST_DUP;
					end
				end else if (!hit_q) begin
					res_ld       = 1'b1;
					res_status_n = skrt_pkg::ST_NOT_FOUND;
				end
			end
			S_SHIFT: begin
				rd_addr = sh_q - AW'(1);
				wr_en   = wb_pend_q;
			end
			S_PLACE: begin
				wr_en        = 1'b1;
				wr_addr      = hit_idx_q[AW-1:0];
				wr_data      = new_rec;
				res_ld       = 1'b1;
				res_slot_n   = hit_idx32[skrt_pkg::SLOT_W-1:0];
				res_rec_n    = new_rec;
			end
			S_UPDATE: begin
				wr_addr = hit_idx_q[AW-1:0];
				wr_data = upd_rec;
				res_ld  = 1'b1;
				if (underflow) begin
					res_status_n = skrt_pkg::ST_UNDERFLOW;
				end else begin
					wr_en      = (cmd_q != skrt_pkg::CMD_FIND);
					res_slot_n = hit_idx32[skrt_pkg::SLOT_W-1:0];
					res_rec_n  = upd_rec;
				end
			end
			default: begin
				rd_addr = scan_q[AW-1:0];
			end
		endcase
	end

	// record memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			table_limit_q   <= skrt_pkg::LIMIT_W'(64);
			released_role_q <= '0;
			occ_q           <= '0;
			scan_q          <= '0;
			rd_pend_q       <= 1'b0;
			rd_at_q         <= '0;
			hit_q           <= 1'b0;
			hit_idx_q       <= '0;
			sh_q            <= '0;
			wb_pend_q       <= 1'b0;
			wb_at_q         <= '0;
			res_pend_q      <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			// take configuration writes
			if (cfg_we) begin
				if (cfg_addr == skrt_pkg::REG_TABLE_LIMIT) begin
					table_limit_q <= cfg_wdata[skrt_pkg::LIMIT_W-1:0];
				end else begin
					released_role_q <= cfg_wdata;
				end
			end

			// refill the output register from the pending result, else drain it
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (res_ld) begin
				res_pend_q <= 1'b1;
			end else if (out_load) begin
				res_pend_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept && !res_ld) begin
						scan_q    <= '0;
						rd_pend_q <= 1'b0;
						state_q   <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (search_stop) begin
						hit_q     <= cmp_eq;
						hit_idx_q <= CW'(rd_at_q);
						rd_pend_q <= 1'b0;
						state_q   <= S_CHECK;
					end else if (scan_q < occ_q) begin
						rd_pend_q <= 1'b1;
						rd_at_q   <= scan_q[AW-1:0];
						scan_q    <= scan_q + CW'(1);
					end else if (!rd_pend_q) begin
						hit_q     <= 1'b0;
						hit_idx_q <= occ_q;
						state_q   <= S_CHECK;
					end else begin
						rd_pend_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (res_ld) begin
						state_q <= S_IDLE;
					end else if (cmd_q == skrt_pkg::CMD_INSERT) begin
						sh_q      <= occ_q[AW-1:0];
						wb_pend_q <= 1'b0;
						state_q   <= S_SHIFT;
					end else begin
						state_q <= S_UPDATE;
					end
				end
				S_SHIFT: begin
					// move records up one slot from the top down to the insert point
					if (sh_q > hit_idx_q[AW-1:0]) begin
						wb_pend_q <= 1'b1;
						wb_at_q   <= sh_q;
						sh_q      <= sh_q - AW'(1);
					end else if (!wb_pend_q) begin
						state_q <= S_PLACE;
					end else begin
						wb_pend_q <= 1'b0;
					end
				end
				S_PLACE: begin
					occ_q   <= occ_q + CW'(1);
					state_q <= S_IDLE;
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tuser;
			key_q   <= s_tdata[63:0];
			owner_q <= s_tdata[127:64];
			start_q <= s_tdata[159:128];
			role_q  <= s_tdata[191:160];
			tref_q  <= s_tdata[255:192];
			delta_q <= s_tdata[287:256];
		end
		if ((state_q == S_SEARCH) && search_stop) begin
			rec_q <= rd_q;
		end
		if (res_ld) begin
			res_status_q <= res_status_n;
			res_slot_q   <= res_slot_n;
			res_rec_q    <= res_rec_n;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_rec_q    <= res_rec_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, out_rec_q.tref, out_rec_q.role, out_rec_q.owner,
		out_rec_q.count, out_slot_q};

endmodule

>>> tb/skrt_table_monitor.sv
// Result checker for the sorted key record table: tracks register writes and command
// beats, keeps its own copy of the table and compares every result beat against it.
// Depends on skrt_pkg for the record layout, widths and the command and status codes.
module skrt_table_monitor
	import skrt_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_addr,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [287:0]               s_tdata,
	input  logic [CMD_W-1:0]           s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [199:0]               m_tdata,
	input  logic [STAT_W-1:0]          m_tuser,
	output int                         mismatches,
	output int                         awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
		logic [OWNER_W-1:0] owner;
		logic [ROLE_W-1:0]  role;
		logic [TREF_W-1:0]  tref;
	} outcome_t;

	logic [LIMIT_W-1:0] limit_reg = 7'd64;
	logic [ROLE_W-1:0]  released_role_reg = '0;
	int unsigned        occupancy = 0;
	rec_t               rec_store [DEPTH_DEFAULT];
	outcome_t           outcome_q [$];
	int                 fault_total = 0;

	// position of the first stored key not below the one asked for
	function automatic int unsigned locate(input logic [KEY_W-1:0] key, output bit hit);
		int unsigned i;
		hit = 1'b0;
		for (i = 0; i < occupancy; i++) begin
			if (rec_store[i].key == key) begin
				hit = 1'b1;
				return i;
			end
			if (rec_store[i].key > key)
				return i;
		end
		return i;
	endfunction

	// apply one command to the table copy and return the result it should give
	function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [287:0] beat);
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] delta;
		logic [COUNT_W-1:0] removal;
		int unsigned        lim;
		int unsigned        pos;
		bit                 hit;
		outcome_t           res;
		key   = beat[63:0];
		delta = beat[287:256];
		lim   = (limit_reg > DEPTH_DEFAULT) ? DEPTH_DEFAULT : limit_reg;
		res   = '0;
		if (cmd == CMD_INSERT) begin
			if (key == '0) begin
				res.status = ST_ZERO_KEY;
				return res;
			end
			if (occupancy >= lim) begin
				res.status = ST_FULL;
				return res;
			end
			pos = locate(key, hit);
			if (hit) begin
				res.status = ST_DUP;
				return res;
			end
			// open a hole at the sorted position
			for (int i = occupancy; i > pos; i--)
				rec_store[i] = rec_store[i-1];
			rec_store[pos].key   = key;
			rec_store[pos].owner = beat[127:64];
			rec_store[pos].count = beat[159:128];
			rec_store[pos].role  = beat[191:160];
			rec_store[pos].tref  = (beat[255:192] != '0) ? beat[255:192] : key;
			occupancy++;
		end else begin
			pos = locate(key, hit);
			if (!hit) begin
				res.status = ST_NOT_FOUND;
				return res;
			end
			if (cmd == CMD_ADJUST) begin
				if (delta[COUNT_W-1]) begin
					// negative delta: refuse to go below zero
					removal = '0 - delta;
					if (removal > rec_store[pos].count) begin
						res.status = ST_UNDERFLOW;
						return res;
					end
					rec_store[pos].count = rec_store[pos].count - removal;
				end else begin
					rec_store[pos].count = rec_store[pos].count + delta;
				end
			end else if (cmd == CMD_RELEASE) begin
				rec_store[pos].owner = '0;
				rec_store[pos].count = '0;
				rec_store[pos].role  = released_role_reg;
			end
		end
		res.status = ST_OK;
		res.slot   = pos[SLOT_W-1:0];
		res.count  = rec_store[pos].count;
		res.owner  = rec_store[pos].owner;
		res.role   = rec_store[pos].role;
		res.tref   = rec_store[pos].tref;
		return res;
	endfunction

	task automatic report_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			fault_total++;
		end
	endtask

	// track registers, predict on command beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			limit_reg = 7'd64;
			released_role_reg = '0;
			occupancy = 0;
			for (int i = 0; i < DEPTH_DEFAULT; i++)
				rec_store[i] = '0;
			outcome_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_TABLE_LIMIT)
					limit_reg = cfg_wdata[LIMIT_W-1:0];
				else if (cfg_addr == REG_RELEASED_ROLE)
					released_role_reg = cfg_wdata[ROLE_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual status %0d data %h",
						$time, m_tuser, m_tdata);
					fault_total++;
				end else begin
					want = outcome_q.pop_front();
					report_field("status", 64'(want.status), 64'(m_tuser));
					report_field("slot", 64'(want.slot), 64'(m_tdata[5:0]));
					report_field("count_out", 64'(want.count), 64'(m_tdata[37:6]));
					report_field("owner_out", want.owner, m_tdata[101:38]);
					report_field("role_out", 64'(want.role), 64'(m_tdata[133:102]));
					report_field("ref_out", want.tref, m_tdata[197:134]);
					report_field("pad bits", 64'd0, 64'(m_tdata[199:198]));
				end
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(apply_command(s_tuser, s_tdata));
		end
		mismatches <= fault_total;
		awaited <= outcome_q.size();
	end

endmodule

>>> tb/tb_sorted_key_record_table.sv
// Top of the sorted key record table testbench: clock, reset, register writes,
// directed and random command beats and the final verdict.
// Depends on skrt_pkg, sorted_key_record_table and skrt_table_monitor.
module tb_sorted_key_record_table;
	timeunit 1ns;
	timeprecision 1ps;

	import skrt_pkg::*;

	localparam int          PHASES      = 7;
	localparam int          PHASE_ITEMS = 220;
	localparam int          STEADY_TAIL = 150;
	localparam int          POOL_SIZE   = 80;
	localparam int          CYCLE_LIMIT = 1_000_000;

	localparam logic [63:0] K_LO  = 64'h0000_0000_0000_0001;
	localparam logic [63:0] K_HI  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] K_MID = 64'h8000_0000_0000_0000;
	localparam logic [63:0] K_A   = 64'h0000_0000_0000_0100;
	localparam logic [63:0] K_B   = 64'h7FFF_FFFF_FFFF_FFFF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_addr = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [287:0]       s_tdata = '0;
	logic [CMD_W-1:0]   s_tuser = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [199:0]       m_tdata;
	logic [STAT_W-1:0]  m_tuser;

	int                 mismatches;
	int                 awaited;
	int                 cycle_count = 0;
	bit                 steady = 1'b0;
	int                 key_span = 16;
	logic [63:0]        key_pool [POOL_SIZE];

	sorted_key_record_table #(
		.DEPTH(DEPTH_DEFAULT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	skrt_table_monitor i_monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.mismatches(mismatches),
		.awaited   (awaited)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[sorted_key_record_table] ERROR");
			$finish;
		end
	end

	// result side: drop tready in random bursts, hold it high in the steady tail
	initial begin
		forever begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// drive one command beat and hold it until accepted
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [63:0] key,
			input logic [63:0] owner, input logic [31:0] cnt, input logic [31:0] role,
			input logic [63:0] tref, input logic [31:0] delta);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {delta, tref, role, cnt, owner, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// lower tvalid and wait until every result has come back
	task automatic quiesce(input int settle);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly keys from the active pool so lookups hit, some misses and zeros
	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 12)
			return {$urandom, $urandom};
		return key_pool[$urandom_range(0, key_span - 1)];
	endfunction

	task automatic random_command();
		logic [CMD_W-1:0] cmd;
		logic [63:0]      key;
		logic [31:0]      cnt;
		logic [31:0]      delta;
		logic [63:0]      tref;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 35)
			cmd = CMD_INSERT;
		else if (r < 65)
			cmd = CMD_ADJUST;
		else if (r < 75)
			cmd = CMD_RELEASE;
		else
			cmd = CMD_FIND;
		key  = pick_key();
		tref = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0, 1, 2, 3: cnt = 32'($urandom_range(0, 40));
			4, 5:       cnt = $urandom;
			6:          cnt = 32'hFFFF_FFFF;
			default:    cnt = 32'h8000_0000;
		endcase
		// small steps hit exact zero and underflow, the rest cover wrap and extremes
		case ($urandom_range(0, 9))
			0, 1, 2, 3: delta = 32'($urandom_range(0, 80)) - 32'd40;
			4, 5:       delta = $urandom;
			6:          delta = 32'h8000_0000;
			7:          delta = 32'h7FFF_FFFF;
			8:          delta = 32'd0 - 32'($urandom_range(1, 1 << 20));
			default:    delta = 32'hFFFF_FFFF;
		endcase
		// idle the command side now and then
		if (!steady && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 13)) @(negedge clk);
		end
		send_command(cmd, key, {$urandom, $urandom}, cnt, $urandom, tref, delta);
	endtask

	function automatic logic [LIMIT_W-1:0] limit_for_phase(input int p);
		case (p)
			0:       return 7'd12;
			1:       return 7'd0;
			2:       return 7'd30;
			3:       return 7'd127;
			4:       return 7'd100;
			default: return 7'd64;
		endcase
	endfunction

	initial begin
		logic [LIMIT_W-1:0] lim;
		logic [31:0]        role_sel;
		int                 span_need;
		key_pool[0] = K_LO;
		key_pool[1] = K_HI;
		key_pool[2] = K_MID;
		key_pool[3] = K_A;
		key_pool[4] = K_B;
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(2, 4000))
				: {$urandom, $urandom};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table: every lookup misses, key zero rejected
		send_command(CMD_FIND, K_LO, '0, '0, '0, '0, '0);
		send_command(CMD_ADJUST, '0, '0, '0, '0, '0, 32'd1);
		send_command(CMD_RELEASE, K_HI, '0, '0, '0, '0, '0);
		send_command(CMD_INSERT, '0, '1, '1, '1, '1, '0);
		// fill out of order to force shifts; zero reference takes the key
		send_command(CMD_INSERT, K_MID, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
		send_command(CMD_INSERT, K_HI, '0, '0, '0, '1, '0);
		send_command(CMD_INSERT, K_LO, {$urandom, $urandom}, 32'h8000_0000, $urandom,
			{$urandom, $urandom}, '0);
		send_command(CMD_INSERT, K_A, {$urandom, $urandom}, 32'd5, $urandom, '0, '0);
		send_command(CMD_INSERT, K_MID, '0, '0, '0, '0, '0);
		send_command(CMD_INSERT, K_B, {$urandom, $urandom}, '0, $urandom, '0, '0);
		send_command(CMD_FIND, K_MID, '0, '0, '0, '0, '0);
		send_command(CMD_FIND, 64'd2, '0, '0, '0, '0, '0);
		send_command(CMD_FIND, '0, '0, '0, '0, '0, '0);
		// count wrap, underflow, exact zero, most negative and most positive deltas
		send_command(CMD_ADJUST, K_MID, '0, '0, '0, '0, 32'd1);
		send_command(CMD_ADJUST, K_HI, '0, '0, '0, '0, 32'hFFFF_FFFF);
		send_command(CMD_ADJUST, K_A, '0, '0, '0, '0, 32'hFFFF_FFFB);
		send_command(CMD_ADJUST, K_LO, '0, '0, '0, '0, 32'h8000_0000);
		send_command(CMD_ADJUST, K_LO, '0, '0, '0, '0, 32'h8000_0000);
		send_command(CMD_ADJUST, K_B, '0, '0, '0, '0, 32'h7FFF_FFFF);
		send_command(CMD_RELEASE, K_MID, '0, '0, '0, '0, '0);
		send_command(CMD_FIND, K_MID, '0, '0, '0, '0, '0);

		// limit lowered below occupancy: inserts answer full, zero key still first
		quiesce(4);
		write_reg(REG_TABLE_LIMIT, 32'd3);
		write_reg(REG_RELEASED_ROLE, 32'hA5A5_5A5A);
		send_command(CMD_INSERT, 64'd3, '0, '0, '0, '0, '0);
		send_command(CMD_INSERT, '0, '0, '0, '0, '0, '0);
		send_command(CMD_INSERT, K_MID, '0, '0, '0, '0, '0);
		send_command(CMD_RELEASE, K_HI, '0, '0, '0, '0, '0);

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			quiesce(4);
			lim = limit_for_phase(p);
			case (p % 3)
				0:       role_sel = $urandom;
				1:       role_sel = 32'hFFFF_FFFF;
				default: role_sel = 32'h0000_0000;
			endcase
			write_reg(REG_RELEASED_ROLE, role_sel);
			write_reg(REG_TABLE_LIMIT, 32'(lim));
			// widen the key pool along with the table
			span_need = (lim >= DEPTH_DEFAULT) ? POOL_SIZE : int'(lim) + int'(lim) / 4 + 4;
			if (span_need > key_span)
				key_span = span_need;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				steady = (p == PHASES - 1) && (n >= PHASE_ITEMS - STEADY_TAIL);
				random_command();
			end
		end

		quiesce(160);
		if (mismatches == 0 && awaited == 0)
			$display("[sorted_key_record_table] OK");
		else
			$display("[sorted_key_record_table] ERROR");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/skrt_pkg.sv
hw/rtl/sorted_key_record_table.sv
tb/skrt_table_monitor.sv
tb/tb_sorted_key_record_table.sv
